/* design/rht_pkg.sv */
package rht_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2
  } rht_cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } rht_status_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rect_id;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] size_w;
    logic [7:0] size_h;
  } rht_in_t;

  typedef struct packed {
    logic [7:0] hit_id;
    logic [1:0] status;
    logic [5:0] entry_count;
  } rht_out_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
  } rht_rec_t;

  // scan token walking down the cell row
  typedef struct packed {
    logic       valid;
    logic       is_query;
    logic [7:0] key;
    logic [7:0] qx;
    logic [7:0] qy;
    logic [7:0] x2;
    logic [7:0] y2;
    logic       found;
    logic [7:0] hit_id;
  } rht_tok_t;

  // packed 16-bit add of (y:x) + (h:w); carry of the low byte reaches the high byte
  function automatic logic [15:0] far_corner(input logic [7:0] x, input logic [7:0] y,
                                             input logic [7:0] w, input logic [7:0] h);
    far_corner = {y, x} + {h, w};
  endfunction

endpackage

/* design/rht_cell.sv */
module rht_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              wr_i,
  input  rht_pkg::rht_rec_t wr_rec_i,
  input  rht_pkg::rht_rec_t next_rec_i,
  input  rht_pkg::rht_tok_t tok_i,
  output rht_pkg::rht_tok_t tok_o,
  output rht_pkg::rht_rec_t rec_o
);

  rht_pkg::rht_rec_t rec_q;
  rht_pkg::rht_tok_t tok_d, tok_q;
  logic [15:0]       far;
  logic              hit, match, shift;

  assign far   = rht_pkg::far_corner(rec_q.x, rec_q.y, rec_q.w, rec_q.h);
  assign hit   = valid_i && (tok_i.x2 >= rec_q.x) && (tok_i.y2 >= rec_q.y) &&
                 (far[7:0] > tok_i.qx) && (far[15:8] > tok_i.qy);
  assign match = valid_i && (rec_q.id == tok_i.key);
  assign shift = tok_i.valid && !tok_i.is_query && (tok_i.found || match);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.is_query) begin
      if (!tok_i.found && hit) begin
        tok_d.found  = 1'b1;
        tok_d.hit_id = rec_q.id;
      end
    end else if (match) begin
      tok_d.found = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      rec_q <= wr_rec_i;
    end else if (shift) begin
      rec_q <= next_rec_i;
    end
  end

  assign tok_o = tok_q;
  assign rec_o = rec_q;

endmodule

/* design/rect_hit_table.sv */
// Ordered table of byte rectangles held in a row of CAPACITY cells, one record each.
// Append and unused commands do not scan: done_o pulses the cycle after the transfer.
// Delete and hit query send a token down the cell row, one cell per cycle: it is
// registered in tok0_q, then in each cell, and done_o is registered as it leaves
// the last cell. busy is high while a token is in flight. Each result shows on
// result_o with done_o; the receiver cannot stall it, so it must take every result.
module rect_hit_table #(
  parameter int CAPACITY = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rht_pkg::rht_in_t  in_i,
  output logic              done_o,
  output rht_pkg::rht_out_t result_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              done_q;
  rht_pkg::rht_out_t result_q;
  rht_pkg::rht_tok_t tok0_q;
  rht_pkg::rht_tok_t tok [CAPACITY+1];
  rht_pkg::rht_rec_t rec [CAPACITY];
  rht_pkg::rht_rec_t wr_rec;
  logic              accept, full, do_append, is_scan;
  logic [15:0]       qfar;
  logic [CntW+5:0]   cnt_ext;

  assign accept    = start && (state_q == S_IDLE);
  assign full      = count_q >= CntW'(CAPACITY);
  assign do_append = accept && (in_i.command == rht_pkg::CMD_APPEND) && !full;
  assign is_scan   = (in_i.command == rht_pkg::CMD_DELETE) ||
                     (in_i.command == rht_pkg::CMD_QUERY);
  assign qfar      = rht_pkg::far_corner(in_i.pos_x, in_i.pos_y, in_i.size_w, in_i.size_h);
  assign wr_rec    = '{id: in_i.rect_id, x: in_i.pos_x, y: in_i.pos_y,
                       w: in_i.size_w, h: in_i.size_h};

  assign tok[0] = tok0_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rht_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (count_q > CntW'(i)),
      .wr_i      (do_append && (count_q == CntW'(i))),
      .wr_rec_i  (wr_rec),
      .next_rec_i(rec[(i + 1 < CAPACITY) ? i + 1 : i]),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1]),
      .rec_o     (rec[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_append) begin
      count_d = count_q + CntW'(1);
    end else if (state_q == S_SCAN && tok[CAPACITY].valid && !tok[CAPACITY].is_query &&
                 tok[CAPACITY].found) begin
      count_d = count_q - CntW'(1);
    end
    cnt_ext = {6'd0, count_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      tok0_q  <= '0;
    end else begin
      count_q <= count_d;
      unique case (state_q)
        S_IDLE: begin
          done_q       <= accept && !is_scan;
          tok0_q.valid <= accept && is_scan;
          if (accept) begin
            tok0_q.is_query <= (in_i.command == rht_pkg::CMD_QUERY);
            tok0_q.key      <= in_i.rect_id;
            tok0_q.qx       <= in_i.pos_x;
            tok0_q.qy       <= in_i.pos_y;
            tok0_q.x2       <= qfar[7:0] - 8'd1;
            tok0_q.y2       <= qfar[15:8] - 8'd1;
            tok0_q.found    <= 1'b0;
            tok0_q.hit_id   <= 8'd0;
          end
          if (accept && is_scan) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          done_q       <= tok[CAPACITY].valid;
          tok0_q.valid <= 1'b0;
          if (tok[CAPACITY].valid) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q.hit_id      <= 8'd0;
      result_q.status      <= (in_i.command == rht_pkg::CMD_APPEND && full) ?
                              rht_pkg::ST_FULL : rht_pkg::ST_OK;
      result_q.entry_count <= cnt_ext[5:0];
    end else if (state_q == S_SCAN && tok[CAPACITY].valid) begin
      result_q.entry_count <= cnt_ext[5:0];
      if (tok[CAPACITY].is_query) begin
        result_q.hit_id <= tok[CAPACITY].found ? tok[CAPACITY].hit_id : 8'd0;
        result_q.status <= rht_pkg::ST_OK;
      end else begin
        result_q.hit_id <= 8'd0;
        result_q.status <= tok[CAPACITY].found ? rht_pkg::ST_OK : rht_pkg::ST_NOTFOUND;
      end
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

/* design/rht_checker.sv */
module rht_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input rht_pkg::rht_in_t  in_i,
  input logic              done_o,
  input rht_pkg::rht_out_t result_o
);

  logic xfer;
  assign xfer = start && !busy;

  a_append_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && in_i.command == rht_pkg::CMD_APPEND |=> done_o && !busy)
    else $error("append result missing");

  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && (in_i.command == rht_pkg::CMD_QUERY || in_i.command == rht_pkg::CMD_DELETE)
    |=> busy && !done_o)
    else $error("scan did not start");

  a_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("scan ended without result");

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status != rht_pkg::ST_OK |-> result_o.hit_id == 8'd0)
    else $error("hit id with error status");

endmodule

bind rect_hit_table rht_checker u_rht_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .in_i    (in_i),
  .done_o  (done_o),
  .result_o(result_o)
);
